// ----- rtl/roi_hist_pkg.sv -----
// Shared types and constants for the ROI gray-level histogram block.
// Used by every module of the block but the RAM; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package roi_hist_pkg;

    // Histogram geometry.
    localparam int NUM_BINS  = 256;
    localparam int BIN_BITS  = 8;

    // Field widths of the channels.
    localparam int OP_BITS       = 2;
    localparam int RESULT_BITS   = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 14;
    localparam int DIM_CFG_BITS  = 13;
    localparam int WIN_CFG_BITS  = 14;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LEFT   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_TOP    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_RIGHT  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_BOTTOM = 3'd5;

    // Input operation codes; the reserved code is a no-op.
    typedef enum logic [OP_BITS-1:0] {
        OP_FRAME_START = 2'd0,
        OP_PIXEL       = 2'd1,
        OP_READ_BIN    = 2'd2,
        OP_RESERVED    = 2'd3
    } op_t;

    // Work handed from the front to the back.
    typedef enum logic [1:0] {
        CMD_NOP   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_COUNT = 2'd2,
        CMD_READ  = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [BIN_BITS-1:0]   addr;
        logic                  window_empty;
    } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/roi_gray_histogram.sv -----
// 256-bin gray histogram over a clipped window: a request passes through the
// command queue, the execute stage and the result register to a valid result.
// Throughput is one request per cycle while results are taken, set by the bin
// RAM's read-modify-write pipeline with a write bypass; a clear is one command.
// Reset is synchronous, active low; bins are cleared at once by per-bin valid
// flags, so no clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module roi_gray_histogram #(
    parameter int MAX_DIMENSION = 4096,
    parameter int COUNT_BITS    = 32
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic [roi_hist_pkg::OP_BITS-1:0]        s_operation,
    input  wire logic [roi_hist_pkg::BIN_BITS-1:0]       s_pixel_value,
    input  wire logic [roi_hist_pkg::BIN_BITS-1:0]       s_bin_index,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic [roi_hist_pkg::RESULT_BITS-1:0]         m_bin_count,
    output logic                                         m_window_empty,
    output logic                                         m_pixel_counted,
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [roi_hist_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [roi_hist_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    roi_hist_pkg::cmd_t push_cmd, pop_cmd;
    logic               push_valid, queue_full, pop_valid, pop_ready;

    // Request classification.
    roi_hist_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_pixel_value (s_pixel_value),
        .s_bin_index   (s_bin_index),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .queue_full    (queue_full),
        .push_valid    (push_valid),
        .push_cmd      (push_cmd)
    );

    // Command queue between the two halves.
    roi_hist_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // Histogram execution and result register.
    roi_hist_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd_valid       (pop_valid),
        .cmd_in          (pop_cmd),
        .cmd_ready       (pop_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_bin_count     (m_bin_count),
        .m_window_empty  (m_window_empty),
        .m_pixel_counted (m_pixel_counted)
    );

endmodule

`default_nettype wire

// ----- rtl/roi_hist_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module roi_hist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; holds its data until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/roi_hist_queue.sv -----
// Short command queue that decouples the front from the back.
// Depends on roi_hist_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module roi_hist_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push_valid,
    input  roi_hist_pkg::cmd_t       push_cmd,
    output logic                     full,
    output logic                     pop_valid,
    input  wire logic                pop_ready,
    output roi_hist_pkg::cmd_t       pop_cmd
);

    localparam int PTR_BITS = $clog2(roi_hist_pkg::QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(roi_hist_pkg::QUEUE_DEPTH + 1);

    roi_hist_pkg::cmd_t  entry_reg [roi_hist_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;
    assign full      = (count_reg == CNT_BITS'(roi_hist_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    // Pointer and fill-count update.
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_BITS'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    // The front must never offer a request while the queue is full.
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push_valid && full))
        else $error("command pushed into a full queue");

    // The fill count stays within the depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(roi_hist_pkg::QUEUE_DEPTH))
        else $error("queue fill count out of range");

    // A push alone raises the count by exactly one.
    a_push_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push && !do_pop |=> count_reg == $past(count_reg) + CNT_BITS'(1))
        else $error("queue count did not follow a push");
`endif

endmodule

`default_nettype wire

// ----- rtl/roi_hist_front.sv -----
// Front end: configuration registers, window clipping, raster position and
// classification of each request into a command. Depends on roi_hist_pkg.
`timescale 1ns / 1ps
`default_nettype none

module roi_hist_front #(
    parameter int MAX_DIMENSION = 4096
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic [roi_hist_pkg::OP_BITS-1:0]        s_operation,
    input  wire logic [roi_hist_pkg::BIN_BITS-1:0]       s_pixel_value,
    input  wire logic [roi_hist_pkg::BIN_BITS-1:0]       s_bin_index,
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [roi_hist_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [roi_hist_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                                    queue_full,
    output logic                                         push_valid,
    output roi_hist_pkg::cmd_t                           push_cmd
);

    localparam int DIM_BITS = $clog2(MAX_DIMENSION + 1);
    localparam int COL_BITS = $clog2(MAX_DIMENSION);
    localparam int CW       = ((DIM_BITS > roi_hist_pkg::WIN_CFG_BITS) ?
                               DIM_BITS : roi_hist_pkg::WIN_CFG_BITS) + 2;
    localparam int WB       = roi_hist_pkg::WIN_CFG_BITS;
    localparam int HB       = roi_hist_pkg::DIM_CFG_BITS;
    localparam logic signed [CW-1:0]   MAX_DIM_S = CW'(MAX_DIMENSION);
    localparam logic [DIM_BITS-1:0]    MAX_DIM_U = DIM_BITS'(MAX_DIMENSION);

    // Configuration registers.
    logic [HB-1:0]        image_width_reg, image_height_reg;
    logic signed [WB-1:0] window_left_reg, window_top_reg;
    logic signed [WB-1:0] window_right_reg, window_bottom_reg;

    // Frame state.
    logic [COL_BITS-1:0]  col_reg, col_next;
    logic [DIM_BITS-1:0]  line_reg, line_next;
    logic [DIM_BITS-1:0]  clip_left_reg, clip_top_reg, clip_right_reg, clip_bottom_reg;
    logic [DIM_BITS-1:0]  clip_left_next, clip_top_next, clip_right_next, clip_bottom_next;
    logic                 empty_reg, empty_next;

    logic signed [CW-1:0] width_s, height_s, width_raw, height_raw;
    logic signed [CW-1:0] left_s, top_s, right_s, bottom_s;
    logic signed [CW-1:0] col_plus_s;
    logic                 accept, in_window;
    roi_hist_pkg::op_t    op;

    // Bring a signed bound into 0..MAX_DIMENSION.
    function automatic logic [DIM_BITS-1:0] clip_dim(input logic signed [CW-1:0] v);
        logic [DIM_BITS-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > MAX_DIM_S) begin
            r = MAX_DIM_U;
        end else begin
            r = v[DIM_BITS-1:0];
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = !queue_full;
    assign accept    = s_valid && s_ready;
    assign op        = roi_hist_pkg::op_t'(s_operation);

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg   <= HB'(4096);
            image_height_reg  <= HB'(4096);
            window_left_reg   <= '0;
            window_top_reg    <= '0;
            window_right_reg  <= WB'(4096);
            window_bottom_reg <= WB'(4096);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                roi_hist_pkg::CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[HB-1:0];
                roi_hist_pkg::CFG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[HB-1:0];
                roi_hist_pkg::CFG_WINDOW_LEFT:   window_left_reg   <= cfg_data;
                roi_hist_pkg::CFG_WINDOW_TOP:    window_top_reg    <= cfg_data;
                roi_hist_pkg::CFG_WINDOW_RIGHT:  window_right_reg  <= cfg_data;
                roi_hist_pkg::CFG_WINDOW_BOTTOM: window_bottom_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective image size and window clipping for a frame start.
    always_comb begin
        width_raw  = CW'(image_width_reg);
        height_raw = CW'(image_height_reg);
        width_s    = (width_raw  > MAX_DIM_S) ? MAX_DIM_S : width_raw;
        height_s   = (height_raw > MAX_DIM_S) ? MAX_DIM_S : height_raw;
        left_s     = {{(CW-WB){window_left_reg[WB-1]}},   window_left_reg};
        top_s      = {{(CW-WB){window_top_reg[WB-1]}},    window_top_reg};
        right_s    = {{(CW-WB){window_right_reg[WB-1]}},  window_right_reg};
        bottom_s   = {{(CW-WB){window_bottom_reg[WB-1]}}, window_bottom_reg};
        clip_left_next   = clip_dim(left_s);
        clip_top_next    = clip_dim(top_s);
        clip_right_next  = clip_dim((right_s  < width_s)  ? right_s  : width_s);
        clip_bottom_next = clip_dim((bottom_s < height_s) ? bottom_s : height_s);
        empty_next = (clip_right_next <= clip_left_next) ||
                     (clip_bottom_next <= clip_top_next);
    end

    // Window test and raster stepping for a pixel.
    always_comb begin
        in_window = !empty_reg &&
                    (DIM_BITS'(col_reg) >= clip_left_reg) &&
                    (DIM_BITS'(col_reg) <  clip_right_reg) &&
                    (line_reg >= clip_top_reg) && (line_reg < clip_bottom_reg);
        col_plus_s = CW'(col_reg) + CW'(1);
        if (col_plus_s >= width_s) begin
            col_next  = '0;
            line_next = (line_reg < MAX_DIM_U) ? line_reg + DIM_BITS'(1) : line_reg;
        end else begin
            col_next  = col_plus_s[COL_BITS-1:0];
            line_next = line_reg;
        end
    end

    // Frame state update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg         <= '0;
            line_reg        <= '0;
            clip_left_reg   <= '0;
            clip_top_reg    <= '0;
            clip_right_reg  <= '0;
            clip_bottom_reg <= '0;
            empty_reg       <= 1'b1;
        end else if (accept) begin
            unique case (op)
                roi_hist_pkg::OP_FRAME_START: begin
                    col_reg         <= '0;
                    line_reg        <= '0;
                    clip_left_reg   <= clip_left_next;
                    clip_top_reg    <= clip_top_next;
                    clip_right_reg  <= clip_right_next;
                    clip_bottom_reg <= clip_bottom_next;
                    empty_reg       <= empty_next;
                end
                roi_hist_pkg::OP_PIXEL: begin
                    col_reg  <= col_next;
                    line_reg <= line_next;
                end
                roi_hist_pkg::OP_READ_BIN, roi_hist_pkg::OP_RESERVED: ;
            endcase
        end
    end

    // Classify the request into a command for the back end.
    always_comb begin
        push_valid            = accept;
        push_cmd.kind         = roi_hist_pkg::CMD_NOP;
        push_cmd.addr         = s_pixel_value;
        push_cmd.window_empty = empty_reg;
        unique case (op)
            roi_hist_pkg::OP_FRAME_START: begin
                push_cmd.kind         = roi_hist_pkg::CMD_CLEAR;
                push_cmd.window_empty = empty_next;
            end
            roi_hist_pkg::OP_PIXEL: begin
                push_cmd.kind = in_window ? roi_hist_pkg::CMD_COUNT : roi_hist_pkg::CMD_NOP;
            end
            roi_hist_pkg::OP_READ_BIN: begin
                push_cmd.kind = roi_hist_pkg::CMD_READ;
                push_cmd.addr = s_bin_index;
            end
            roi_hist_pkg::OP_RESERVED: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    // The line position saturates at the maximum dimension.
    a_line_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg <= MAX_DIM_U)
        else $error("line position beyond maximum dimension");

    // A pixel is only ever counted in a non-empty window.
    a_count_needs_window: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid && push_cmd.kind == roi_hist_pkg::CMD_COUNT |-> !empty_reg)
        else $error("pixel counted in an empty window");

    // A frame start puts the raster back to the first pixel.
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && op == roi_hist_pkg::OP_FRAME_START |=> col_reg == '0 && line_reg == '0)
        else $error("raster position not reset by frame start");
`endif

endmodule

`default_nettype wire

// ----- rtl/roi_hist_back.sv -----
// Back end: carries out queued commands against the bin RAM with a
// read-modify-write pipeline and drives the result register.
// Depends on roi_hist_pkg and roi_hist_ram.
`timescale 1ns / 1ps
`default_nettype none

module roi_hist_back #(
    parameter int COUNT_BITS = 32
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cmd_valid,
    input  roi_hist_pkg::cmd_t                          cmd_in,
    output logic                                        cmd_ready,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic [roi_hist_pkg::RESULT_BITS-1:0]        m_bin_count,
    output logic                                        m_window_empty,
    output logic                                        m_pixel_counted
);

    localparam int RB = roi_hist_pkg::RESULT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Execute stage.
    logic                  exec_valid_reg;
    roi_hist_pkg::cmd_t    exec_cmd_reg;
    logic                  fwd_hit_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;
    logic [roi_hist_pkg::NUM_BINS-1:0] bin_valid_reg;

    // Result register.
    logic                  m_valid_reg;
    logic [RB-1:0]         m_bin_count_reg;
    logic                  m_window_empty_reg;
    logic                  m_pixel_counted_reg;

    logic                  exec_fire, issue;
    logic                  is_count, is_clear, is_read;
    logic [COUNT_BITS-1:0] ram_rd_data, cur_count, new_count;
    logic [RB-1:0]         read_value;

    assign is_count  = (exec_cmd_reg.kind == roi_hist_pkg::CMD_COUNT);
    assign is_clear  = (exec_cmd_reg.kind == roi_hist_pkg::CMD_CLEAR);
    assign is_read   = (exec_cmd_reg.kind == roi_hist_pkg::CMD_READ);
    assign exec_fire = exec_valid_reg && (!m_valid_reg || m_ready);
    assign issue     = cmd_valid && (!exec_valid_reg || exec_fire);
    assign cmd_ready = issue;

    roi_hist_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (roi_hist_pkg::NUM_BINS)
    ) u_bins (
        .aclk    (aclk),
        .wr_en   (exec_fire && is_count),
        .wr_addr (exec_cmd_reg.addr),
        .wr_data (new_count),
        .rd_en   (issue),
        .rd_addr (cmd_in.addr),
        .rd_data (ram_rd_data)
    );

    // Current bin value: cleared bins read as zero, and a write made while
    // this read was issued is taken from the bypass.
    always_comb begin
        if (!bin_valid_reg[exec_cmd_reg.addr]) begin
            cur_count = '0;
        end else if (fwd_hit_reg) begin
            cur_count = fwd_data_reg;
        end else begin
            cur_count = ram_rd_data;
        end
        new_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_BITS'(1);
    end

    // Fit the bin count into the result field, saturating wide counters.
    generate
        if (COUNT_BITS > RB) begin : g_wide
            assign read_value = (cur_count[COUNT_BITS-1:RB] != '0) ? {RB{1'b1}}
                                                                   : cur_count[RB-1:0];
        end else begin : g_narrow
            assign read_value = RB'(cur_count);
        end
    endgenerate

    // Execute stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exec_valid_reg <= 1'b0;
            bin_valid_reg  <= '0;
        end else begin
            if (issue) begin
                exec_valid_reg <= 1'b1;
            end else if (exec_fire) begin
                exec_valid_reg <= 1'b0;
            end
            if (exec_fire && is_clear) begin
                bin_valid_reg <= '0;
            end else if (exec_fire && is_count) begin
                bin_valid_reg[exec_cmd_reg.addr] <= 1'b1;
            end
        end
    end

    // Execute stage payload and write bypass.
    always_ff @(posedge aclk) begin
        if (issue) begin
            exec_cmd_reg <= cmd_in;
            fwd_hit_reg  <= exec_fire && is_count && (exec_cmd_reg.addr == cmd_in.addr);
            fwd_data_reg <= new_count;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (exec_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            m_bin_count_reg     <= is_read ? read_value : '0;
            m_window_empty_reg  <= exec_cmd_reg.window_empty;
            m_pixel_counted_reg <= is_count;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_bin_count     = m_bin_count_reg;
    assign m_window_empty  = m_window_empty_reg;
    assign m_pixel_counted = m_pixel_counted_reg;

`ifndef NO_ASSERTIONS
    // A clear leaves every bin reading as zero.
    a_clear_all: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire && is_clear |=> bin_valid_reg == '0)
        else $error("bins not cleared by frame start");

    // A counted pixel leaves its bin marked as written.
    a_count_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire && is_count |=> bin_valid_reg[$past(exec_cmd_reg.addr)])
        else $error("counted bin not marked valid");

    // A counted pixel never reports a bin count.
    a_counted_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_pixel_counted_reg |-> m_bin_count_reg == '0)
        else $error("pixel result carries a bin count");

    // The bypass is only armed after a count was executed.
    a_fwd_source: assert property (@(posedge aclk) disable iff (!aresetn)
        issue && exec_fire && is_count && exec_cmd_reg.addr == cmd_in.addr |=> fwd_hit_reg)
        else $error("bypass missed a back-to-back count");
`endif

endmodule

`default_nettype wire
